/* rtl/assert_macros.svh */
// Assertion helpers. The using module must have i_clk and i_rst_n.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked only while out of reset.
`define AST_RUN(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// Checked at every edge, reset included.
`define AST_ALL(label, prop, msg) \
    label: assert property (@(posedge i_clk) prop) else $error(msg);

`endif

/* rtl/admix_pkg.sv */
`timescale 1ns / 1ps

package admix_pkg;

    localparam int SAMPLE_W   = 16;
    localparam int VOL_W      = 7;
    localparam int LEVEL_W    = 10;
    localparam int SUM_W      = 41;
    localparam int COUNT_W    = 11;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 7;

    localparam logic [CFG_IDX_W-1:0] CFG_VOLUME = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_STEREO = 2'd1;

    localparam int VOL_MAX           = 100;
    localparam int LEVEL_MAX         = 1000;
    localparam int FULL_SCALE        = 32767;
    localparam int BLOCK_SAMPLES_DEF = 960;

    // floor(2^29 / 100): underestimates x/100 by less than one for x < 2^22
    localparam int RECIP100       = 5368709;
    localparam int RECIP100_SHIFT = 29;
    // 32769 / 2^30 underestimates 1/32767 by less than one step for 25-bit roots
    localparam int RECIP_FS       = 32769;
    localparam int RECIP_FS_SHIFT = 30;
    localparam int ROOT_SCALE     = 1000000;

    // mean of squares fits 31 bits; scaled radicand fits 50 bits
    localparam int MEAN_W     = 31;
    localparam int RAD_W      = 50;
    localparam int ROOT_W     = RAD_W / 2;
    localparam int DIV_STEPS  = MEAN_W;
    localparam int SQRT_STEPS = ROOT_W;
    localparam int CNT_W      = $clog2(DIV_STEPS);

    typedef struct packed {
        logic capture;
        logic mix;
        logic scale;
        logic square;
        logic accum;
        logic div_step;
        logic rmul;
        logic sqrt_step;
        logic lest;
        logic lfix;
        logic smooth;
        logic load_out;
    } t_cmd;

    typedef struct packed {
        logic close;
        logic out_free;
    } t_status;

endpackage

/* rtl/admix_ctrl.sv */
`timescale 1ns / 1ps
`include "assert_macros.svh"

module admix_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_stall,
    input  admix_pkg::t_status i_status,
    output admix_pkg::t_cmd    o_cmd
);

    typedef enum logic [11:0] {
        S_IDLE   = 12'b0000_0000_0001,
        S_MIX    = 12'b0000_0000_0010,
        S_SCALE  = 12'b0000_0000_0100,
        S_SQUARE = 12'b0000_0000_1000,
        S_ACCUM  = 12'b0000_0001_0000,
        S_DIV    = 12'b0000_0010_0000,
        S_RMUL   = 12'b0000_0100_0000,
        S_SQRT   = 12'b0000_1000_0000,
        S_LEST   = 12'b0001_0000_0000,
        S_LFIX   = 12'b0010_0000_0000,
        S_SMOOTH = 12'b0100_0000_0000,
        S_DONE   = 12'b1000_0000_0000
    } t_state;

    localparam logic [admix_pkg::CNT_W-1:0] DIV_LAST  =
        admix_pkg::CNT_W'(admix_pkg::DIV_STEPS - 1);
    localparam logic [admix_pkg::CNT_W-1:0] SQRT_LAST =
        admix_pkg::CNT_W'(admix_pkg::SQRT_STEPS - 1);

    t_state                        r_state, n_state;
    logic [admix_pkg::CNT_W-1:0]   r_cnt, n_cnt;
    logic                          w_accept;

    assign o_in_stall = (r_state != S_IDLE) || !i_rst_n;
    assign w_accept   = i_in_valid && !o_in_stall;

    always_comb begin
        n_state = r_state;
        n_cnt   = r_cnt;
        case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    n_state = S_MIX;
                end
            end
            S_MIX:    n_state = S_SCALE;
            S_SCALE:  n_state = S_SQUARE;
            S_SQUARE: n_state = S_ACCUM;
            S_ACCUM: begin
                n_state = i_status.close ? S_DIV : S_DONE;
            end
            S_DIV: begin
                if (r_cnt == DIV_LAST) begin
                    n_cnt   = '0;
                    n_state = S_RMUL;
                end else begin
                    n_cnt = r_cnt + 1'b1;
                end
            end
            S_RMUL: n_state = S_SQRT;
            S_SQRT: begin
                if (r_cnt == SQRT_LAST) begin
                    n_cnt   = '0;
                    n_state = S_LEST;
                end else begin
                    n_cnt = r_cnt + 1'b1;
                end
            end
            S_LEST:   n_state = S_LFIX;
            S_LFIX:   n_state = S_SMOOTH;
            S_SMOOTH: n_state = S_DONE;
            S_DONE: begin
                if (i_status.out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
                n_cnt   = '0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
        end
    end

    always_comb begin
        o_cmd           = '0;
        o_cmd.capture   = w_accept;
        o_cmd.mix       = (r_state == S_MIX);
        o_cmd.scale     = (r_state == S_SCALE);
        o_cmd.square    = (r_state == S_SQUARE);
        o_cmd.accum     = (r_state == S_ACCUM);
        o_cmd.div_step  = (r_state == S_DIV);
        o_cmd.rmul      = (r_state == S_RMUL);
        o_cmd.sqrt_step = (r_state == S_SQRT);
        o_cmd.lest      = (r_state == S_LEST);
        o_cmd.lfix      = (r_state == S_LFIX);
        o_cmd.smooth    = (r_state == S_SMOOTH);
        o_cmd.load_out  = (r_state == S_DONE) && i_status.out_free;
    end

    `AST_RUN(a_accept_starts, w_accept |=> (r_state == S_MIX), "accepted sample did not start")
    `AST_RUN(a_div_exit, (r_state == S_DIV && r_cnt == DIV_LAST) |=> (r_state == S_RMUL), "divider overran")
    `AST_ALL(a_load_free, o_cmd.load_out |-> i_status.out_free, "result loaded over held result")
    `AST_RUN(a_cnt_idle, !(r_state == S_DIV || r_state == S_SQRT) |-> (r_cnt == '0), "step counter not parked")

endmodule

/* rtl/admix_dp.sv */
`timescale 1ns / 1ps

module admix_dp #(
    parameter int BLOCK_SAMPLES = admix_pkg::BLOCK_SAMPLES_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  logic [admix_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [admix_pkg::CFG_DATA_W-1:0]    i_cfg_data,
    input  logic signed [admix_pkg::SAMPLE_W-1:0] i_left_sample,
    input  logic signed [admix_pkg::SAMPLE_W-1:0] i_right_sample,
    input  logic                                i_end_of_frame,
    input  logic                                i_new_stream,
    input  admix_pkg::t_cmd                     i_cmd,
    output admix_pkg::t_status                  o_status,
    input  logic                                i_out_stall,
    output logic                                o_out_valid,
    output logic signed [admix_pkg::SAMPLE_W-1:0] o_mono_sample,
    output logic                                o_level_valid,
    output logic [admix_pkg::LEVEL_W-1:0]       o_rms_level,
    output logic [admix_pkg::LEVEL_W-1:0]       o_beat_level
);

    localparam int SW   = admix_pkg::SAMPLE_W;
    localparam int PW   = SW + admix_pkg::VOL_W;        // |sample| * volume
    localparam int LW   = admix_pkg::LEVEL_W;
    localparam int CW   = admix_pkg::COUNT_W;
    localparam int MW   = admix_pkg::MEAN_W;
    localparam int RW   = admix_pkg::RAD_W;
    localparam int QW   = admix_pkg::ROOT_W;
    localparam int SRW  = QW + 1;                       // sqrt remainder
    localparam int HW   = admix_pkg::SUM_W - MW;        // dividend head bits
    localparam logic [CW-1:0] BLK_LIM = CW'(BLOCK_SAMPLES);
    localparam logic [LW-1:0] LMAX    = LW'(admix_pkg::LEVEL_MAX);

    // configuration
    logic [admix_pkg::VOL_W-1:0] r_volume;
    logic                        r_stereo;
    logic [admix_pkg::VOL_W-1:0] w_cfg_vol;

    assign w_cfg_vol = (i_cfg_data > admix_pkg::CFG_DATA_W'(admix_pkg::VOL_MAX))
                     ? admix_pkg::VOL_W'(admix_pkg::VOL_MAX)
                     : admix_pkg::VOL_W'(i_cfg_data);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_volume <= admix_pkg::VOL_W'(admix_pkg::VOL_MAX);
            r_stereo <= 1'b0;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                admix_pkg::CFG_VOLUME: r_volume <= w_cfg_vol;
                admix_pkg::CFG_STEREO: r_stereo <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    // downmix and gain
    logic signed [SW:0]   w_pair, w_half, w_src, w_mag17;
    logic [SW-1:0]        w_mag;
    logic [PW-1:0]        w_prod;
    logic                 w_neg;

    assign w_pair  = {i_left_sample[SW-1], i_left_sample}
                   + {i_right_sample[SW-1], i_right_sample};
    assign w_half  = w_pair[SW] ? ((w_pair + (SW+1)'(1)) >>> 1) : (w_pair >>> 1);
    assign w_src   = r_stereo ? w_half : {i_left_sample[SW-1], i_left_sample};
    assign w_neg   = w_src[SW];
    assign w_mag17 = w_neg ? -w_src : w_src;
    assign w_mag   = w_mag17[SW-1:0];
    assign w_prod  = PW'(w_mag) * PW'(r_volume);

    logic [PW-1:0]        r_prod;
    logic                 r_neg;
    logic                 r_eof;
    logic [SW-1:0]        r_qest;
    logic signed [SW-1:0] r_mono;
    logic [2*SW-2:0]      r_sq;

    logic [2*PW-1:0]      w_qprod;
    logic [PW-1:0]        w_qx100, w_qrem;
    logic [SW-1:0]        w_q;
    logic signed [2*SW-1:0] w_sq_full;

    assign w_qprod   = (2*PW)'(r_prod) * (2*PW)'(admix_pkg::RECIP100);
    assign w_qx100   = PW'(r_qest) * PW'(admix_pkg::VOL_MAX);
    assign w_qrem    = r_prod - w_qx100;
    assign w_q       = r_qest + SW'(w_qrem >= PW'(admix_pkg::VOL_MAX));
    assign w_sq_full = r_mono * r_mono;

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_prod <= w_prod;
            r_neg  <= w_neg;
            r_eof  <= i_end_of_frame;
        end
        if (i_cmd.mix) begin
            r_qest <= w_qprod[admix_pkg::RECIP100_SHIFT +: SW];
        end
        if (i_cmd.scale) begin
            r_mono <= r_neg ? -$signed(w_q) : $signed(w_q);
        end
        if (i_cmd.square) begin
            r_sq <= w_sq_full[2*SW-2:0];
        end
    end

    // block accumulator
    logic [admix_pkg::SUM_W-1:0] r_sum, w_sum_new;
    logic [CW-1:0]               r_count, w_count_new;
    logic                        w_close;

    assign w_sum_new   = r_sum + admix_pkg::SUM_W'(r_sq);
    assign w_count_new = r_count + 1'b1;
    assign w_close     = r_eof || (w_count_new >= BLK_LIM);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sum   <= '0;
            r_count <= '0;
        end else if (i_cmd.accum) begin
            r_sum   <= w_close ? '0 : w_sum_new;
            r_count <= w_close ? '0 : w_count_new;
        end
    end

    // restoring divider for the mean, one quotient bit per step
    logic [CW-1:0] r_rem, r_divisor, w_rem_next;
    logic [MW-1:0] r_dq;
    logic [CW:0]   w_trial;
    logic          w_ge;
    logic          r_blk;

    assign w_trial    = {r_rem, r_dq[MW-1]};
    assign w_ge       = w_trial >= {1'b0, r_divisor};
    assign w_rem_next = w_ge ? CW'(w_trial - {1'b0, r_divisor}) : CW'(w_trial);

    always_ff @(posedge i_clk) begin
        if (i_cmd.accum) begin
            r_blk <= w_close;
            if (w_close) begin
                r_rem     <= CW'(w_sum_new[admix_pkg::SUM_W-1 -: HW]);
                r_dq      <= w_sum_new[MW-1:0];
                r_divisor <= w_count_new;
            end
        end else if (i_cmd.div_step) begin
            r_rem <= w_rem_next;
            r_dq  <= {r_dq[MW-2:0], w_ge};
        end
    end

    // digit-by-digit square root, one root bit per step
    logic [RW-1:0]  r_rad;
    logic [QW-1:0]  r_root;
    logic [SRW-1:0] r_srem;
    logic [MW+19:0] w_rad_full;
    logic [SRW+1:0] w_sshift, w_strial;
    logic           w_sge;

    assign w_rad_full = (MW+20)'(r_dq) * (MW+20)'(admix_pkg::ROOT_SCALE);
    assign w_sshift   = {r_srem, r_rad[RW-1 -: 2]};
    assign w_strial   = (SRW+2)'({r_root, 2'b01});
    assign w_sge      = w_sshift >= w_strial;

    always_ff @(posedge i_clk) begin
        if (i_cmd.rmul) begin
            r_rad  <= w_rad_full[RW-1:0];
            r_root <= '0;
            r_srem <= '0;
        end else if (i_cmd.sqrt_step) begin
            r_rad  <= {r_rad[RW-3:0], 2'b00};
            r_root <= {r_root[QW-2:0], w_sge};
            r_srem <= w_sge ? SRW'(w_sshift - w_strial) : SRW'(w_sshift);
        end
    end

    // level = root / full scale, then smoothing
    logic [LW-1:0]   r_lq, r_level, r_smooth, r_rms, r_beat;
    logic [QW+15:0]  w_lprod;
    logic [QW-1:0]   w_lqx, w_ldiff;
    logic [LW:0]     w_lvl;
    logic [LW+1:0]   w_sm_sum;
    logic [LW-1:0]   w_sm, w_bdiff;

    assign w_lprod  = (QW+16)'(r_root) * (QW+16)'(admix_pkg::RECIP_FS);
    assign w_lqx    = (QW'(r_lq) << 15) - QW'(r_lq);
    assign w_ldiff  = r_root - w_lqx;
    assign w_lvl    = (LW+1)'(r_lq) + (LW+1)'(w_ldiff >= QW'(admix_pkg::FULL_SCALE));
    assign w_sm_sum = (LW+2)'(r_smooth) * (LW+2)'(3) + (LW+2)'(r_level);
    assign w_sm     = w_sm_sum[LW+1:2];
    assign w_bdiff  = r_level - w_sm;

    always_ff @(posedge i_clk) begin
        if (i_cmd.lest) begin
            r_lq <= w_lprod[admix_pkg::RECIP_FS_SHIFT +: LW];
        end
        if (i_cmd.lfix) begin
            r_level <= (w_lvl > (LW+1)'(LMAX)) ? LMAX : LW'(w_lvl);
        end
        if (i_cmd.smooth) begin
            r_rms  <= (w_sm > LMAX) ? LMAX : w_sm;
            r_beat <= (r_level > w_sm) ? ((w_bdiff > LMAX) ? LMAX : w_bdiff) : '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_smooth <= '0;
        end else if (i_cmd.capture && i_new_stream) begin
            r_smooth <= '0;
        end else if (i_cmd.smooth) begin
            r_smooth <= w_sm;
        end
    end

    // output register
    logic                 r_out_valid;
    logic signed [SW-1:0] r_o_mono;
    logic                 r_o_lv;
    logic [LW-1:0]        r_o_rms, r_o_beat;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.load_out) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_out) begin
            r_o_mono <= r_mono;
            r_o_lv   <= r_blk;
            r_o_rms  <= r_blk ? r_rms : '0;
            r_o_beat <= r_blk ? r_beat : '0;
        end
    end

    assign o_status.close    = w_close;
    assign o_status.out_free = !r_out_valid || !i_out_stall;
    assign o_out_valid       = r_out_valid;
    assign o_mono_sample     = r_o_mono;
    assign o_level_valid     = r_o_lv;
    assign o_rms_level       = r_o_rms;
    assign o_beat_level      = r_o_beat;

endmodule

/* rtl/audio_downmix_volume_level_meter.sv */
`timescale 1ns / 1ps
// Channel  | direction | handshake              | payload
// ---------+-----------+------------------------+------------------------------------------
// in       | sink      | i_in_valid / o_in_stall | left, right, end_of_frame, new_stream
// out      | source    | o_out_valid / i_out_stall | mono, level_valid, rms, beat
// cfg      | sink      | i_cfg_we (no wait)     | i_cfg_index, i_cfg_data
//
// A sample is taken only while the controller is idle; it then passes through mix, gain,
// square and accumulate before the next can be taken, and a sample that closes a block also
// runs the mean divider (one bit per cycle) and the square root unit (one bit per cycle).
// Synchronous active-low reset; o_in_stall is high while reset is held.
// A finished result sits in the output register; the next sample is taken while it waits,
// and only the hand-off of the following result waits on i_out_stall.

module audio_downmix_volume_level_meter #(
    parameter int BLOCK_SAMPLES = admix_pkg::BLOCK_SAMPLES_DEF
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    // configuration
    input  logic                                  i_cfg_we,
    input  logic [admix_pkg::CFG_IDX_W-1:0]       i_cfg_index,
    input  logic [admix_pkg::CFG_DATA_W-1:0]      i_cfg_data,
    // sample input
    input  logic                                  i_in_valid,
    output logic                                  o_in_stall,
    input  logic signed [admix_pkg::SAMPLE_W-1:0] i_left_sample,
    input  logic signed [admix_pkg::SAMPLE_W-1:0] i_right_sample,
    input  logic                                  i_end_of_frame,
    input  logic                                  i_new_stream,
    // result output
    output logic                                  o_out_valid,
    input  logic                                  i_out_stall,
    output logic signed [admix_pkg::SAMPLE_W-1:0] o_mono_sample,
    output logic                                  o_level_valid,
    output logic [admix_pkg::LEVEL_W-1:0]         o_rms_level,
    output logic [admix_pkg::LEVEL_W-1:0]         o_beat_level
);

    // Controller sequences each sample: mix, gain, square, accumulate; on block close
    // it runs the mean divider, root scale, square root, full-scale divide and smoothing.
    admix_pkg::t_cmd    w_cmd;
    admix_pkg::t_status w_status;

    admix_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_status   (w_status),
        .o_cmd      (w_cmd)
    );

    // Datapath holds config, block accumulator, iterative divider and square root units and output register.
    admix_dp #(
        .BLOCK_SAMPLES (BLOCK_SAMPLES)
    ) u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data),
        .i_left_sample  (i_left_sample),
        .i_right_sample (i_right_sample),
        .i_end_of_frame (i_end_of_frame),
        .i_new_stream   (i_new_stream),
        .i_cmd          (w_cmd),
        .o_status       (w_status),
        .i_out_stall    (i_out_stall),
        .o_out_valid    (o_out_valid),
        .o_mono_sample  (o_mono_sample),
        .o_level_valid  (o_level_valid),
        .o_rms_level    (o_rms_level),
        .o_beat_level   (o_beat_level)
    );

endmodule
